[rtl/core/assert_macros.svh]
// Assertion helpers for the RTL. Define NO_ASSERTIONS to strip them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check prop at every rising clock edge outside reset.
`define PFC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that cons holds in the cycle after ante, outside reset.
`define PFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PFC_ASSERT(label, clk, rst, prop, msg)
`define PFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/core/pfc_pkg.sv]
`timescale 1ns / 1ps

package pfc_pkg;

  // Input item codes
  typedef enum logic [1:0] {
    MODE_KEY    = 2'd0,
    MODE_FINISH = 2'd1,
    MODE_TEXT   = 2'd2,
    MODE_END    = 2'd3
  } mode_t;

  // ASCII bounds used when cleaning a byte
  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] CASE_GAP     = 8'd32;

  // Output letter base
  localparam logic [6:0] LETTER_A = 7'd65;

  // Letter indexes (A is zero)
  localparam logic [4:0] IDX_I       = 5'd8;
  localparam logic [4:0] IDX_J       = 5'd9;
  localparam logic [4:0] IDX_X       = 5'd23;
  localparam logic [4:0] ALPHA_LAST  = 5'd25;
  localparam logic [4:0] SQUARE_CELLS = 5'd25;

  // Grid geometry
  localparam logic [2:0] GRID_LAST = 3'd4;
  localparam logic [4:0] GRID_SIDE = 5'd5;

  typedef struct packed {
    logic       ok;
    logic [4:0] idx;
  } letter_t;

  // Square write: slot gets letter, letter's position gets {row, col}
  typedef struct packed {
    logic       we;
    logic [4:0] slot;
    logic [4:0] letter;
    logic [5:0] rc;
  } sq_wr_t;

  // Square reads: two position lookups and two cell lookups
  typedef struct packed {
    logic [4:0] pos_a;
    logic [4:0] pos_b;
    logic [4:0] cell_a;
    logic [4:0] cell_b;
  } sq_rd_t;

  typedef struct packed {
    logic [5:0] pos_a;
    logic [5:0] pos_b;
    logic [4:0] let_a;
    logic [4:0] let_b;
  } sq_rdata_t;

  // Upper-case, fold J into I, flag non-letters
  function automatic letter_t clean_letter(input logic [7:0] ch);
    letter_t    r;
    logic [7:0] up;
    logic [7:0] off;
    up = (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) ? ch - CASE_GAP : ch;
    r.ok = (up >= CHAR_UPPER_A && up <= CHAR_UPPER_Z);
    off = up - CHAR_UPPER_A;
    r.idx = (off[4:0] == IDX_J) ? IDX_I : off[4:0];
    return r;
  endfunction

  // Split a cell number 0..24 into {row, col}; row = num*52 >> 8
  function automatic logic [5:0] cell_rc(input logic [4:0] num);
    logic [10:0] prod;
    logic [2:0]  row;
    logic [4:0]  base;
    logic [4:0]  col;
    prod = 11'(num) * 11'd52;
    row  = prod[10:8];
    base = 5'({2'b00, row} * GRID_SIDE);
    col  = num - base;
    return {row, col[2:0]};
  endfunction

  // Join {row, col} into a cell number
  function automatic logic [4:0] rc_cell(input logic [2:0] row, input logic [2:0] col);
    return 5'({2'b00, row} * GRID_SIDE + {2'b00, col});
  endfunction

  // Step a row or column by one around the grid, forward or back
  function automatic logic [2:0] grid_step(input logic [2:0] x, input logic back);
    logic [2:0] r;
    if (back) begin
      r = (x == 3'd0) ? GRID_LAST : x - 3'd1;
    end else begin
      r = (x == GRID_LAST) ? 3'd0 : x + 3'd1;
    end
    return r;
  endfunction

endpackage

[rtl/core/pfc_if.sv]
`timescale 1ns / 1ps

// Byte channel into the cipher
interface pfc_char_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] char_in;

  modport source (output valid, output mode, output char_in, input ready);
  modport sink (input valid, input mode, input char_in, output ready);
endinterface

// Letter pair channel out of the cipher
interface pfc_pair_if;
  logic       valid;
  logic       ready;
  logic [6:0] first_letter;
  logic [6:0] second_letter;

  modport source (output valid, output first_letter, output second_letter, input ready);
  modport sink (input valid, input first_letter, input second_letter, output ready);
endinterface

[rtl/core/playfair_digraph_cipher.sv]
`timescale 1ns / 1ps

// Channel     Dir   Payload                         Beat when
// char_chan   in    mode[1:0], char_in[7:0]         valid && ready
// pair_chan   out   first_letter, second_letter     valid && ready
// cfg         in    cfg_wdata (decrypt_mode)        cfg_we
//
// Key byte: placed as it is accepted. Finish key: an alphabet walk that
// checks one letter per cycle and places the unused ones through the
// single square write port. Text letter that completes a pair, or end
// with a letter pending: position lookup, then cell lookup, then load.
// A finished pair sits in the output register while the next byte is taken;
// the following pair waits in ST_EMIT until that register is free.
// rst is synchronous; the key square is undefined until the key is finished.

`include "assert_macros.svh"

module playfair_digraph_cipher (
  input logic        clk,
  input logic        rst,
  pfc_char_if.sink   char_chan,
  pfc_pair_if.source pair_chan,
  input logic        cfg_we,
  input logic        cfg_wdata
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_FILL = 5'b00010,
    ST_LOOK = 5'b00100,
    ST_MAP  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t     state;
  logic       decrypt_mode;
  logic [25:0] used_letters;
  logic [4:0] fill_count;
  logic       key_complete;
  logic       pending_valid;
  logic [4:0] pending_letter;
  logic [4:0] walk;
  logic [4:0] a_reg;
  logic [4:0] b_reg;

  logic              acc;
  pfc_pkg::letter_t  cl;
  logic              take_first;
  logic              start_pair;
  logic              keep_pending;
  logic [4:0]        pair_b;
  logic              finish_start;
  logic              place_req;
  logic [4:0]        place_idx;
  logic              place_do;
  logic              emit_fire;

  pfc_pkg::sq_wr_t    sq_wr;
  pfc_pkg::sq_rd_t    sq_rd;
  pfc_pkg::sq_rdata_t sq_q;

  logic [2:0] r1, c1, r2, c2;
  logic [4:0] o1, o2;

  assign char_chan.ready = (state == ST_IDLE);
  assign acc = char_chan.valid && char_chan.ready;
  assign cl  = pfc_pkg::clean_letter(char_chan.char_in);

  // Decode the accepted byte
  always_comb begin
    take_first   = 1'b0;
    start_pair   = 1'b0;
    keep_pending = 1'b0;
    pair_b       = pfc_pkg::IDX_X;
    finish_start = acc && (char_chan.mode == pfc_pkg::MODE_FINISH) && !key_complete;
    if (acc && key_complete) begin
      if (char_chan.mode == pfc_pkg::MODE_TEXT && cl.ok) begin
        if (!pending_valid) begin
          take_first = 1'b1;
        end else begin
          start_pair = 1'b1;
          if (!decrypt_mode && cl.idx == pending_letter) begin
            keep_pending = 1'b1;
          end else begin
            pair_b = cl.idx;
          end
        end
      end else if (char_chan.mode == pfc_pkg::MODE_END && pending_valid) begin
        start_pair = 1'b1;
      end
    end
  end

  // Pick the letter to place: a key byte or the alphabet walk
  always_comb begin
    place_req = 1'b0;
    place_idx = walk;
    if (state == ST_FILL) begin
      place_req = 1'b1;
    end else if (acc && char_chan.mode == pfc_pkg::MODE_KEY && !key_complete) begin
      place_req = cl.ok;
      place_idx = cl.idx;
    end
  end

  assign place_do = place_req && !used_letters[place_idx]
                    && (fill_count < pfc_pkg::SQUARE_CELLS);

  assign sq_wr.we     = place_do;
  assign sq_wr.slot   = fill_count;
  assign sq_wr.letter = place_idx;
  assign sq_wr.rc     = pfc_pkg::cell_rc(fill_count);

  // Apply the pair rules to the looked-up positions
  assign r1 = sq_q.pos_a[5:3];
  assign c1 = sq_q.pos_a[2:0];
  assign r2 = sq_q.pos_b[5:3];
  assign c2 = sq_q.pos_b[2:0];

  always_comb begin
    if (r1 == r2) begin
      o1 = pfc_pkg::rc_cell(r1, pfc_pkg::grid_step(c1, decrypt_mode));
      o2 = pfc_pkg::rc_cell(r2, pfc_pkg::grid_step(c2, decrypt_mode));
    end else if (c1 == c2) begin
      o1 = pfc_pkg::rc_cell(pfc_pkg::grid_step(r1, decrypt_mode), c1);
      o2 = pfc_pkg::rc_cell(pfc_pkg::grid_step(r2, decrypt_mode), c2);
    end else begin
      o1 = pfc_pkg::rc_cell(r1, c2);
      o2 = pfc_pkg::rc_cell(r2, c1);
    end
  end

  assign sq_rd.pos_a  = a_reg;
  assign sq_rd.pos_b  = b_reg;
  assign sq_rd.cell_a = o1;
  assign sq_rd.cell_b = o2;

  pfc_square u_square (
    .clk   (clk),
    .wr    (sq_wr),
    .rd    (sq_rd),
    .rdata (sq_q)
  );

  assign emit_fire = (state == ST_EMIT) && (!pair_chan.valid || pair_chan.ready);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      decrypt_mode   <= 1'b0;
      used_letters   <= 26'(1) << pfc_pkg::IDX_J;
      fill_count     <= 5'd0;
      key_complete   <= 1'b0;
      pending_valid  <= 1'b0;
      pending_letter <= 5'd0;
      walk           <= 5'd0;
      pair_chan.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        decrypt_mode <= cfg_wdata;
      end
      // Record a placement
      if (place_do) begin
        used_letters[place_idx] <= 1'b1;
        fill_count              <= fill_count + 5'd1;
      end
      // Track the pending letter
      if (take_first) begin
        pending_valid  <= 1'b1;
        pending_letter <= cl.idx;
      end else if (start_pair && !keep_pending) begin
        pending_valid  <= 1'b0;
        pending_letter <= 5'd0;
      end
      // Drop the output beat once taken, load a new one when free
      if (emit_fire) begin
        pair_chan.valid <= 1'b1;
      end else if (pair_chan.ready) begin
        pair_chan.valid <= 1'b0;
      end
      // Advance the sequencer
      case (state)
        ST_IDLE: begin
          if (finish_start) begin
            walk  <= 5'd0;
            state <= ST_FILL;
          end else if (start_pair) begin
            state <= ST_LOOK;
          end
        end
        ST_FILL: begin
          if (walk == pfc_pkg::ALPHA_LAST) begin
            key_complete <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            walk <= walk + 5'd1;
          end
        end
        ST_LOOK: state <= ST_MAP;
        ST_MAP:  state <= ST_EMIT;
        ST_EMIT: begin
          if (emit_fire) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Pair letters and output payload
  always_ff @(posedge clk) begin
    if (start_pair) begin
      a_reg <= pending_letter;
      b_reg <= pair_b;
    end
    if (emit_fire) begin
      pair_chan.first_letter  <= pfc_pkg::LETTER_A + {2'b00, sq_q.let_a};
      pair_chan.second_letter <= pfc_pkg::LETTER_A + {2'b00, sq_q.let_b};
    end
  end

  `PFC_ASSERT(a_fill_bound, clk, rst, fill_count <= pfc_pkg::SQUARE_CELLS, "fill past square")
  `PFC_ASSERT(a_key_full, clk, rst, !key_complete || fill_count == pfc_pkg::SQUARE_CELLS, "short")
  `PFC_ASSERT(a_pend_key, clk, rst, !pending_valid || key_complete, "pending before key")
  `PFC_ASSERT(a_j_used, clk, rst, used_letters[pfc_pkg::IDX_J], "J lost its used mark")
  `PFC_ASSERT_NEXT(a_load_emit, clk, rst, state == ST_EMIT && !pair_chan.valid, pair_chan.valid, "idle")

endmodule

[rtl/core/pfc_square.sv]
`timescale 1ns / 1ps

// Key square store: cell -> letter and letter -> {row, col}, registered reads
module pfc_square (
  input  logic               clk,
  input  pfc_pkg::sq_wr_t    wr,
  input  pfc_pkg::sq_rd_t    rd,
  output pfc_pkg::sq_rdata_t rdata
);

  logic [4:0] key_square [0:24];
  logic [5:0] letter_position [0:25];

  // Write one placement into both tables
  always_ff @(posedge clk) begin
    if (wr.we) begin
      key_square[wr.slot]        <= wr.letter;
      letter_position[wr.letter] <= wr.rc;
    end
  end

  // Read two positions and two cells every cycle
  always_ff @(posedge clk) begin
    rdata.pos_a <= letter_position[rd.pos_a];
    rdata.pos_b <= letter_position[rd.pos_b];
    rdata.let_a <= key_square[rd.cell_a];
    rdata.let_b <= key_square[rd.cell_b];
  end

endmodule

[tb/playfair_digraph_cipher_tb.sv]
`timescale 1ns / 1ps

module playfair_digraph_cipher_tb;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 5;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES  = 200;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_ITEMS  = 150;
  localparam int PRINT_CAP    = 20;

  typedef struct packed {
    pfc_pkg::mode_t mode;
    logic [7:0]     ch;
  } char_beat_t;

  typedef struct packed {
    logic [6:0] first;
    logic [6:0] second;
  } letter_pair_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  pfc_char_if char_chan ();
  pfc_pair_if pair_chan ();

  playfair_digraph_cipher DUT (
    .clk       (clk),
    .rst       (rst),
    .char_chan (char_chan),
    .pair_chan (pair_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Stimulus and expectations
  char_beat_t   pending_beats[$];
  letter_pair_t expected_pairs[$];
  char_beat_t   next_beat;
  int beats_queued = 0;
  int beats_taken = 0;
  int pairs_checked = 0;
  int mismatch_count = 0;
  int mode_writes = 0;
  logic steady = 1'b0;

  // Sender and receiver pacing
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int holds_asked = 0;
  int holds_served = 0;

  // Cipher state mirror
  logic [4:0]  sq_letter[25];
  int          letter_cell[26];
  logic [25:0] letters_used = 26'd1 << pfc_pkg::IDX_J;
  int          cells_filled = 0;
  logic        square_done = 1'b0;
  logic        held_valid = 1'b0;
  logic [4:0]  held_letter = 5'd0;
  logic        decrypt_on = 1'b0;

  function automatic void square_place(input logic [4:0] idx);
    if (cells_filled < 25 && !letters_used[idx]) begin
      letters_used[idx] = 1'b1;
      sq_letter[cells_filled] = idx;
      letter_cell[idx] = cells_filled;
      cells_filled++;
    end
  endfunction

  // Apply the row, column or rectangle rule to one digraph
  function automatic letter_pair_t cipher_pair(input logic [4:0] a, input logic [4:0] b);
    letter_pair_t p;
    int ra, ca, rb, cb, shift, oa, ob;
    ra = letter_cell[a] / 5;
    ca = letter_cell[a] % 5;
    rb = letter_cell[b] / 5;
    cb = letter_cell[b] % 5;
    shift = decrypt_on ? 4 : 1;
    if (ra == rb) begin
      oa = ra * 5 + (ca + shift) % 5;
      ob = rb * 5 + (cb + shift) % 5;
    end else if (ca == cb) begin
      oa = ((ra + shift) % 5) * 5 + ca;
      ob = ((rb + shift) % 5) * 5 + cb;
    end else begin
      oa = ra * 5 + cb;
      ob = rb * 5 + ca;
    end
    p.first  = pfc_pkg::LETTER_A + 7'(sq_letter[oa]);
    p.second = pfc_pkg::LETTER_A + 7'(sq_letter[ob]);
    return p;
  endfunction

  // Advance the mirror by one accepted beat, queue any pair it yields
  function automatic void cipher_predict(input pfc_pkg::mode_t m, input logic [7:0] ch);
    logic [7:0] up;
    logic       is_letter;
    logic [4:0] idx;
    up = (ch >= pfc_pkg::CHAR_LOWER_A && ch <= pfc_pkg::CHAR_LOWER_Z) ?
         ch - pfc_pkg::CASE_GAP : ch;
    is_letter = (up >= pfc_pkg::CHAR_UPPER_A && up <= pfc_pkg::CHAR_UPPER_Z);
    idx = 5'(up - pfc_pkg::CHAR_UPPER_A);
    if (idx == pfc_pkg::IDX_J) idx = pfc_pkg::IDX_I;
    case (m)
      pfc_pkg::MODE_KEY: begin
        if (!square_done && is_letter) square_place(idx);
      end
      pfc_pkg::MODE_FINISH: begin
        if (!square_done) begin
          for (int i = 0; i < 26; i++) square_place(5'(i));
          square_done = 1'b1;
        end
      end
      pfc_pkg::MODE_TEXT: begin
        if (square_done && is_letter) begin
          if (!held_valid) begin
            held_valid = 1'b1;
            held_letter = idx;
          end else if (!decrypt_on && idx == held_letter) begin
            expected_pairs.push_back(cipher_pair(held_letter, pfc_pkg::IDX_X));
          end else begin
            expected_pairs.push_back(cipher_pair(held_letter, idx));
            held_valid = 1'b0;
          end
        end
      end
      pfc_pkg::MODE_END: begin
        if (square_done && held_valid) begin
          expected_pairs.push_back(cipher_pair(held_letter, pfc_pkg::IDX_X));
          held_valid = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Drive the byte channel from the pending queue, with idle bursts
  always @(posedge clk) begin
    if (rst) begin
      char_chan.valid <= 1'b0;
      char_chan.mode <= pfc_pkg::MODE_KEY;
      char_chan.char_in <= 8'd0;
      send_gap <= 0;
    end else if (!char_chan.valid || char_chan.ready) begin
      if (send_gap != 0) begin
        char_chan.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_beats.size() == 0) begin
        char_chan.valid <= 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        char_chan.valid <= 1'b0;
        send_gap <= $urandom_range(0, 4);
      end else begin
        next_beat = pending_beats.pop_front();
        char_chan.valid <= 1'b1;
        char_chan.mode <= next_beat.mode;
        char_chan.char_in <= next_beat.ch;
      end
    end
  end

  // Pace the pair channel: long hold-off on request, else short stalls
  always @(posedge clk) begin
    if (rst) begin
      pair_chan.ready <= 1'b0;
    end else if (hold_left != 0) begin
      pair_chan.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      pair_chan.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else if (stall_left != 0) begin
      pair_chan.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 4) == 0) begin
      pair_chan.ready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      pair_chan.ready <= 1'b1;
    end
  end

  // Check each output beat, then fold in each input beat
  always @(posedge clk) begin
    if (!rst) begin
      if (pair_chan.valid && pair_chan.ready) begin
        if (expected_pairs.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_CAP)
            $display("%0t: unexpected pair %c%c, nothing expected", $time,
                     pair_chan.first_letter, pair_chan.second_letter);
        end else begin
          letter_pair_t want;
          want = expected_pairs.pop_front();
          pairs_checked++;
          if (pair_chan.first_letter !== want.first ||
              pair_chan.second_letter !== want.second) begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP)
              $display("%0t: pair expected %c%c (%0d,%0d), got %c%c (%0d,%0d)", $time,
                       want.first, want.second, want.first, want.second,
                       pair_chan.first_letter, pair_chan.second_letter,
                       pair_chan.first_letter, pair_chan.second_letter);
          end
        end
      end
      if (char_chan.valid && char_chan.ready) begin
        cipher_predict(pfc_pkg::mode_t'(char_chan.mode), char_chan.char_in);
        beats_taken++;
      end
    end
  end

  task automatic queue_beat(input pfc_pkg::mode_t m, input logic [7:0] ch);
    char_beat_t b;
    b.mode = m;
    b.ch = ch;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic queue_string(input pfc_pkg::mode_t m, input string s);
    for (int i = 0; i < s.len(); i++) queue_beat(m, s[i]);
  endtask

  // Mostly letters with doubles and X runs; some junk, ends and ignored key and finish beats
  task automatic queue_random_text(input int count);
    int counted;
    int sel;
    logic [7:0] prev;
    logic [7:0] ch;
    counted = 0;
    prev = "A";
    while (counted < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        ch = prev;
        queue_beat(pfc_pkg::MODE_TEXT, ch);
      end else if (sel < 62) begin
        ch = ($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25));
        queue_beat(pfc_pkg::MODE_TEXT, ch);
        prev = ch;
      end else if (sel < 72) begin
        queue_beat(pfc_pkg::MODE_TEXT, 8'($urandom_range(0, 255)));
      end else if (sel < 80) begin
        ch = $urandom_range(0, 1) ? "x" : "X";
        queue_beat(pfc_pkg::MODE_TEXT, ch);
        prev = ch;
      end else if (sel < 92) begin
        queue_beat(pfc_pkg::MODE_END, 8'($urandom_range(0, 255)));
      end else if (sel < 96) begin
        queue_beat(pfc_pkg::MODE_KEY, 8'($urandom_range(0, 255)));
        counted--;
      end else begin
        queue_beat(pfc_pkg::MODE_FINISH, 8'($urandom_range(0, 255)));
        counted--;
      end
      counted++;
    end
  endtask

  task automatic write_mode(input logic v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    decrypt_on = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_writes++;
  endtask

  // Wait until every beat is taken and every pair is back, then let the block settle
  task automatic drain_and_settle();
    while (beats_taken != beats_queued || expected_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    write_mode(1'b0);

    // Text and end before the key is finished are dropped
    queue_beat(pfc_pkg::MODE_TEXT, "Q");
    queue_beat(pfc_pkg::MODE_END, 8'h00);
    // Key with mixed case, a space, a repeat and a J folded onto I
    queue_string(pfc_pkg::MODE_KEY, "Play fair eXj");
    queue_beat(pfc_pkg::MODE_FINISH, 8'hff);
    queue_beat(pfc_pkg::MODE_FINISH, 8'h00);
    queue_beat(pfc_pkg::MODE_KEY, "Z");
    // Empty end, row pair, column pair, split double, X run, junk, odd tail
    queue_beat(pfc_pkg::MODE_END, 8'h00);
    queue_string(pfc_pkg::MODE_TEXT, "paPcLLXX5");
    queue_beat(pfc_pkg::MODE_END, 8'hff);
    drain_and_settle();

    write_mode(1'b1);
    queue_random_text(PHASE_ITEMS);
    drain_and_settle();

    // Stall the output long enough to back up the input
    write_mode(1'b0);
    queue_random_text(PHASE_ITEMS);
    holds_asked++;
    drain_and_settle();

    write_mode(1'b1);
    queue_random_text(PHASE_ITEMS);
    drain_and_settle();

    // Closing stretch at full rate
    write_mode(1'b0);
    steady = 1'b1;
    queue_random_text(PHASE_ITEMS);
    drain_and_settle();

    $display("Sent %0d byte beats and checked %0d letter pairs over %0d mode writes,",
             beats_taken, pairs_checked, mode_writes);
    $display("both directions, doubled letters, odd tails and one long output hold-off.");
    if (mismatch_count == 0) begin
      $display("playfair_digraph_cipher: match");
    end else begin
      $display("playfair_digraph_cipher: mismatch");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Timed out with %0d beats taken of %0d, %0d pairs outstanding",
             beats_taken, beats_queued, expected_pairs.size());
    $display("playfair_digraph_cipher: mismatch");
    $finish;
  end

endmodule
